// ===== rtl/core/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, constants and helpers for the frame brightness classifier.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int MAX_FRAME_SIDE = 4096;

  localparam int REG_W  = 13;
  localparam int CNT_W  = $clog2(MAX_FRAME_SIDE);
  localparam int SIDE_W = CNT_W + 1;
  localparam int AREA_W = 2 * CNT_W + 1;
  localparam int SUM_W  = 32;
  localparam int PROD_W = SUM_W + 8;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // x / 10 == (x * 3277) >> 15 for all x below 16384
  localparam int DIV10_MUL   = 3277;
  localparam int DIV10_SHIFT = 15;
  localparam int DIV10_W     = SIDE_W + 12;

  localparam int GRAY_W     = 22;
  localparam int GRAY_B     = 1868;
  localparam int GRAY_G     = 9617;
  localparam int GRAY_R     = 4899;
  localparam int GRAY_ROUND = 8192;
  localparam int GRAY_SHIFT = 14;

  localparam int DARK_BLUE      = 50;
  localparam int BRIGHT_BLUE_LO = 200;
  localparam int BRIGHT_BLUE_HI = 254;

  localparam int DARK_MEAN   = 50;
  localparam int BRIGHT_MEAN = 205;
  localparam int SHARE_NUM   = 3;
  localparam int SHARE_DEN   = 5;
  localparam int GRAY_LOW    = 43;
  localparam int GRAY_MID    = 65;
  localparam int GRAY_HIGH   = 195;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [2:0] light_level;
    logic       light_enough;
    logic       too_bright;
    logic [7:0] average_gray;
  } result_t;

  // Frame totals handed from the front end to the back end
  typedef struct packed {
    logic [SUM_W-1:0]  blue_sum;
    logic [AREA_W-1:0] dark_count;
    logic [AREA_W-1:0] bright_count;
    logic [SUM_W-1:0]  gray_sum;
    logic [SIDE_W-1:0] crop_w;
    logic [SIDE_W-1:0] crop_h;
    logic [SIDE_W-1:0] frame_w;
    logic [SIDE_W-1:0] frame_h;
  } frame_stats_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [REG_W-1:0] raw);
    logic [SIDE_W-1:0] side;
    if (raw == '0) begin
      side = SIDE_W'(1);
    end else if (int'(raw) > MAX_FRAME_SIDE) begin
      side = SIDE_W'(MAX_FRAME_SIDE);
    end else begin
      side = SIDE_W'(raw);
    end
    return side;
  endfunction

  function automatic logic [SIDE_W-1:0] margin_of(input logic [SIDE_W-1:0] side);
    logic [DIV10_W-1:0] prod;
    prod = DIV10_W'(side) * DIV10_W'(DIV10_MUL);
    return SIDE_W'(prod >> DIV10_SHIFT);
  endfunction

endpackage

// ===== rtl/core/frame_brightness_classifier.sv =====
// ----------------------------------------------------------------------------
// frame_brightness_classifier
// Classifies the brightness of a BGR frame streamed in raster order.
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock. Each frame's totals are handed to a
// two-entry queue on the last pixel; the back end then takes the queue entry,
// forms the area products, makes the threshold compare, runs eight divider
// steps for the mean gray and loads the result before the result can be
// taken. Sustained rate is one pixel per cycle while the queue has room;
// when it is full the last pixel of a frame is stalled until a queue entry
// frees. Writing a size register restarts the frame and takes effect on the
// next pixel.
// ----------------------------------------------------------------------------
module frame_brightness_classifier (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [fbc_pkg::REG_W-1:0] cfg_data,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  fbc_pkg::pixel_t           pixel,
  output logic                      result_valid,
  input  logic                      result_stall,
  output fbc_pkg::result_t          result
);
  import fbc_pkg::*;

  q_status_t    q_stat;
  frame_stats_t wr_stats, rd_stats;
  logic         push, pop;

  fbc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .q_stat      (q_stat),
    .push        (push),
    .stats       (wr_stats)
  );

  fbc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_stats),
    .pop     (pop),
    .rd_data (rd_stats),
    .q_stat  (q_stat)
  );

  fbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .pop          (pop),
    .stats        (rd_stats),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> q_stat.full)
    else $error("pixel stall without a full queue");

  a_cfg_clears_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !pixel_stall)
    else $error("pixel stall right after a size write");

  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.light_level <= 3'd4) &&
                     (result.light_enough == (result.light_level > 3'd1)))
    else $error("inconsistent light level fields");

endmodule

// ===== rtl/core/fbc_front.sv =====
// ----------------------------------------------------------------------------
// fbc_front
// Size registers, raster position, crop test and per-frame accumulation.
// Pushes the frame totals into the queue on the last pixel.
// ----------------------------------------------------------------------------
module fbc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [fbc_pkg::REG_W-1:0]   cfg_data,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  fbc_pkg::pixel_t             pixel,
  input  fbc_pkg::q_status_t          q_stat,
  output logic                        push,
  output fbc_pkg::frame_stats_t       stats
);
  import fbc_pkg::*;

  logic [SIDE_W-1:0] width, height, margin_w, margin_h;
  logic [SIDE_W-1:0] w_lim, h_lim, col_ext, row_ext;
  logic [SIDE_W-1:0] cfg_side;
  logic [CNT_W-1:0]  col, row;
  logic              in_crop, is_last, row_end, take;
  logic [GRAY_W-1:0] gray_full;

  logic              p_valid, p_crop, p_last;
  logic [7:0]        p_blue, p_gray;
  logic              p_fire;

  logic [SUM_W-1:0]  blue_sum, blue_sum_next, gray_sum, gray_sum_next;
  logic [AREA_W-1:0] dark_count, dark_count_next, bright_count, bright_count_next;

  assign cfg_side = clamp_side(cfg_data);
  assign w_lim    = width - margin_w;
  assign h_lim    = height - margin_h;
  assign col_ext  = {1'b0, col};
  assign row_ext  = {1'b0, row};

  assign in_crop = (col_ext >= margin_w) && (col_ext < w_lim) &&
                   (row_ext >= margin_h) && (row_ext < h_lim);
  assign row_end = (col_ext >= width - SIDE_W'(1));
  assign is_last = row_end && (row_ext >= height - SIDE_W'(1));

  assign gray_full = GRAY_W'(GRAY_B) * GRAY_W'(pixel.blue)
                   + GRAY_W'(GRAY_G) * GRAY_W'(pixel.green)
                   + GRAY_W'(GRAY_R) * GRAY_W'(pixel.red)
                   + GRAY_W'(GRAY_ROUND);

  // Hold the last pixel of a frame while the queue has no room
  assign pixel_stall = p_valid && p_last && q_stat.full;
  assign take        = pixel_valid && !pixel_stall;
  assign p_fire      = p_valid && !pixel_stall;
  assign push        = p_fire && p_last;

  always_comb begin
    blue_sum_next     = blue_sum;
    dark_count_next   = dark_count;
    bright_count_next = bright_count;
    gray_sum_next     = gray_sum + SUM_W'(p_gray);
    if (p_crop) begin
      blue_sum_next = blue_sum + SUM_W'(p_blue);
      if (p_blue < 8'(DARK_BLUE)) begin
        dark_count_next = dark_count + AREA_W'(1);
      end
      if (p_blue >= 8'(BRIGHT_BLUE_LO) && p_blue <= 8'(BRIGHT_BLUE_HI)) begin
        bright_count_next = bright_count + AREA_W'(1);
      end
    end
  end

  always_comb begin
    stats.blue_sum     = blue_sum_next;
    stats.dark_count   = dark_count_next;
    stats.bright_count = bright_count_next;
    stats.gray_sum     = gray_sum_next;
    stats.crop_w       = width - (margin_w << 1);
    stats.crop_h       = height - (margin_h << 1);
    stats.frame_w      = width;
    stats.frame_h      = height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width        <= SIDE_W'(RESET_WIDTH);
      height       <= SIDE_W'(RESET_HEIGHT);
      margin_w     <= margin_of(SIDE_W'(RESET_WIDTH));
      margin_h     <= margin_of(SIDE_W'(RESET_HEIGHT));
      col          <= '0;
      row          <= '0;
      p_valid      <= 1'b0;
      blue_sum     <= '0;
      dark_count   <= '0;
      bright_count <= '0;
      gray_sum     <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        width    <= cfg_side;
        margin_w <= margin_of(cfg_side);
      end else begin
        height   <= cfg_side;
        margin_h <= margin_of(cfg_side);
      end
      col          <= '0;
      row          <= '0;
      p_valid      <= 1'b0;
      blue_sum     <= '0;
      dark_count   <= '0;
      bright_count <= '0;
      gray_sum     <= '0;
    end else begin
      if (take) begin
        if (is_last) begin
          col <= '0;
          row <= '0;
        end else if (row_end) begin
          col <= '0;
          row <= row + CNT_W'(1);
        end else begin
          col <= col + CNT_W'(1);
        end
      end
      p_valid <= take || pixel_stall;
      if (p_fire) begin
        if (p_last) begin
          blue_sum     <= '0;
          dark_count   <= '0;
          bright_count <= '0;
          gray_sum     <= '0;
        end else begin
          blue_sum     <= blue_sum_next;
          dark_count   <= dark_count_next;
          bright_count <= bright_count_next;
          gray_sum     <= gray_sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_crop <= in_crop;
      p_last <= is_last;
      p_blue <= pixel.blue;
      p_gray <= gray_full[GRAY_SHIFT +: 8];
    end
  end

endmodule

// ===== rtl/core/fbc_queue.sv =====
// ----------------------------------------------------------------------------
// fbc_queue
// Short FIFO of frame totals between the front end and the back end.
// ----------------------------------------------------------------------------
module fbc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  fbc_pkg::frame_stats_t wr_data,
  input  logic                  pop,
  output fbc_pkg::frame_stats_t rd_data,
  output fbc_pkg::q_status_t    q_stat
);
  import fbc_pkg::*;

  frame_stats_t      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_data      = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] ptr);
    return (int'(ptr) == QUEUE_DEPTH - 1) ? '0 : ptr + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/fbc_back.sv =====
// ----------------------------------------------------------------------------
// fbc_back
// Per-frame evaluation: area products, threshold tests, mean-gray divider
// (one quotient bit per cycle) and the result register.
// ----------------------------------------------------------------------------
module fbc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  fbc_pkg::q_status_t    q_stat,
  output logic                  pop,
  input  fbc_pkg::frame_stats_t stats,
  output logic                  result_valid,
  input  logic                  result_stall,
  output fbc_pkg::result_t      result
);
  import fbc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t            state, state_next;
  frame_stats_t      cur;
  logic [AREA_W-1:0] crop_area, all_area;
  logic [SUM_W-1:0]  rem;
  logic [7:0]        quot;
  logic [2:0]        bit_idx;
  logic [2:0]        level;
  logic              enough, bright;
  logic [PROD_W-1:0] bs_ext, gs_ext, crop_ext, all_ext, div_step, rem_ext;
  logic [2:0]        level_calc;
  logic [1:0]        bad_calc;
  logic              out_free, div_hit;

  assign pop      = (state == ST_IDLE) && !q_stat.empty;
  assign out_free = !result_valid || !result_stall;

  assign bs_ext   = PROD_W'(cur.blue_sum);
  assign gs_ext   = PROD_W'(cur.gray_sum);
  assign crop_ext = PROD_W'(crop_area);
  assign all_ext  = PROD_W'(all_area);
  assign rem_ext  = PROD_W'(rem);
  assign div_step = all_ext << bit_idx;
  assign div_hit  = (rem_ext >= div_step);

  always_comb begin
    level_calc = '0;
    bad_calc   = '0;
    if (bs_ext > PROD_W'(DARK_MEAN) * crop_ext) level_calc = level_calc + 3'd1;
    if (PROD_W'(SHARE_DEN) * PROD_W'(cur.dark_count) < PROD_W'(SHARE_NUM) * crop_ext) begin
      level_calc = level_calc + 3'd1;
    end
    if (gs_ext > PROD_W'(GRAY_LOW) * all_ext) level_calc = level_calc + 3'd1;
    if (gs_ext > PROD_W'(GRAY_MID) * all_ext) level_calc = level_calc + 3'd1;
    if (bs_ext > PROD_W'(BRIGHT_MEAN) * crop_ext) bad_calc = bad_calc + 2'd1;
    if (PROD_W'(SHARE_DEN) * PROD_W'(cur.bright_count) > PROD_W'(SHARE_NUM) * crop_ext) begin
      bad_calc = bad_calc + 2'd1;
    end
    if (gs_ext > PROD_W'(GRAY_HIGH) * all_ext) bad_calc = bad_calc + 2'd1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_stat.empty) state_next = ST_MUL;
      ST_MUL:  state_next = ST_CMP;
      ST_CMP:  state_next = ST_DIV;
      ST_DIV:  if (bit_idx == '0) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= stats;
    end
    if (state == ST_MUL) begin
      crop_area <= AREA_W'(cur.crop_w) * AREA_W'(cur.crop_h);
      all_area  <= AREA_W'(cur.frame_w) * AREA_W'(cur.frame_h);
    end
    if (state == ST_CMP) begin
      level   <= level_calc;
      enough  <= (level_calc > 3'd1);
      bright  <= (bad_calc > 2'd1);
      rem     <= cur.gray_sum;
      quot    <= '0;
      bit_idx <= 3'd7;
    end
    if (state == ST_DIV) begin
      if (div_hit) begin
        rem           <= SUM_W'(rem_ext - div_step);
        quot[bit_idx] <= 1'b1;
      end
      bit_idx <= bit_idx - 3'd1;
    end
    if ((state == ST_DONE) && out_free) begin
      result.light_level  <= level;
      result.light_enough <= enough;
      result.too_bright   <= bright;
      result.average_gray <= quot;
    end
  end

endmodule
